// File: hdl/permutation_parity_core_defines.svh
// assertion macros for the permutation parity core checker
`ifndef PERMUTATION_PARITY_CORE_DEFINES_SVH
`define PERMUTATION_PARITY_CORE_DEFINES_SVH

// antecedent holds in the same cycle as the consequent
`define PPERM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PPERM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/pperm_pkg.sv
// shared types and constants for the permutation parity core
package pperm_pkg;

   // default store depth
   localparam int MAX_LEN_DEF = 1024;
   // width of one permutation entry
   localparam int VALUE_W     = 10;
   // stream bus widths, padded to whole bytes
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 8;

   // controller sequencing
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_READ,
      ST_WRITE,
      ST_DONE
   } pperm_state_type;

   // finished parity handed to the output register
   typedef struct packed {
      logic valid;
      logic is_odd;
   } pperm_result_type;

endpackage

// File: hdl/permutation_parity_core.sv
// top level of the permutation parity core
//
// Usage: entries of a permutation arrive on the req_ stream one word per
// cycle in index order, entry_value in req_tdata[9:0]; req_tlast marks the
// final entry. Each entry is written to a forward store at its index and
// its index to an inverse store at its value, so loading runs at one word
// per cycle.
// After the marked word req_tready drops and the block walks the n stored
// entries, one store read then the swap write-back per index, since both
// stores are single-port rams. After the walk the parity result is written
// to the output register, from which it appears on the rsp_ stream.
// The result sits in an output register; loading of the next permutation
// goes on while it waits. If the receiver still holds the previous result
// when a walk ends, the block waits with req_tready low until it is taken.
// Reset (synchronous) empties the entry count, parity and output register;
// the store contents are left as they are and are not cleared between
// permutations.
module permutation_parity_core #(
   parameter int MAX_LEN = pperm_pkg::MAX_LEN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // entry stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pperm_pkg::REQ_DATA_W-1:0]  req_tdata,  // [9:0] entry_value, rest zero
   input  logic                              req_tlast,  // is_last
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pperm_pkg::RSP_DATA_W-1:0]  rsp_tdata   // [0] is_odd, rest zero
);

   import pperm_pkg::*;

   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CNT_W = $clog2(MAX_LEN + 1);

   pperm_result_type   result;
   logic               rsp_free;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_odd_ff, rsp_odd_in;

   logic               fwd_we, fwd_re;
   logic [IDX_W-1:0]   fwd_addr;
   logic [VALUE_W-1:0] fwd_wdata, fwd_rdata;
   logic               inv_we, inv_re;
   logic [IDX_W-1:0]   inv_addr;
   logic [IDX_W-1:0]   inv_wdata, inv_rdata;

   // sequencer
   pperm_ctrl #(
      .MAX_LEN (MAX_LEN),
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_value  (req_tdata[VALUE_W-1:0]),
      .in_last   (req_tlast),
      .rsp_free  (rsp_free),
      .result    (result),
      .fwd_we    (fwd_we),
      .fwd_re    (fwd_re),
      .fwd_addr  (fwd_addr),
      .fwd_wdata (fwd_wdata),
      .fwd_rdata (fwd_rdata),
      .inv_we    (inv_we),
      .inv_re    (inv_re),
      .inv_addr  (inv_addr),
      .inv_wdata (inv_wdata),
      .inv_rdata (inv_rdata)
   );

   // forward store: entry values by index
   pperm_ram #(
      .DEPTH  (MAX_LEN),
      .WIDTH  (VALUE_W),
      .ADDR_W (IDX_W)
   ) u_fwd_ram (
      .clock   (clock),
      .wr_en   (fwd_we),
      .rd_en   (fwd_re),
      .addr    (fwd_addr),
      .wr_data (fwd_wdata),
      .rd_data (fwd_rdata)
   );

   // inverse store: indices by entry value
   pperm_ram #(
      .DEPTH  (MAX_LEN),
      .WIDTH  (IDX_W),
      .ADDR_W (IDX_W)
   ) u_inv_ram (
      .clock   (clock),
      .wr_en   (inv_we),
      .rd_en   (inv_re),
      .addr    (inv_addr),
      .wr_data (inv_wdata),
      .rd_data (inv_rdata)
   );

   // output register
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_odd_in   = rsp_odd_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
         rsp_odd_in   = result.is_odd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_odd_ff <= rsp_odd_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_odd_ff);

endmodule

// File: hdl/pperm_ram.sv
// single-port synchronous ram with registered read data
module pperm_ram #(
   parameter int DEPTH  = 1024,
   parameter int WIDTH  = 10,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wr_data,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one access per cycle: write, or read with the data registered for the next cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end else if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/pperm_ctrl.sv
// load and transposition-walk sequencer for the permutation parity core
module pperm_ctrl #(
   parameter int MAX_LEN = pperm_pkg::MAX_LEN_DEF,
   parameter int IDX_W   = 10,
   parameter int CNT_W   = 11
) (
   input  logic                           clock,
   input  logic                           reset,
   // entry stream
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [pperm_pkg::VALUE_W-1:0]  in_value,
   input  logic                           in_last,
   // result slot
   input  logic                           rsp_free,
   output pperm_pkg::pperm_result_type    result,
   // forward store port
   output logic                           fwd_we,
   output logic                           fwd_re,
   output logic [IDX_W-1:0]               fwd_addr,
   output logic [pperm_pkg::VALUE_W-1:0]  fwd_wdata,
   input  logic [pperm_pkg::VALUE_W-1:0]  fwd_rdata,
   // inverse store port
   output logic                           inv_we,
   output logic                           inv_re,
   output logic [IDX_W-1:0]               inv_addr,
   output logic [IDX_W-1:0]               inv_wdata,
   input  logic [IDX_W-1:0]               inv_rdata
);

   import pperm_pkg::*;

   localparam int CMP_W = (CNT_W > VALUE_W) ? CNT_W : VALUE_W;
   localparam logic [CMP_W-1:0] LEN_CMP = CMP_W'(MAX_LEN);

   pperm_state_type  state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             parity_ff, parity_in;

   logic accept;
   logic load_ok;
   logic value_ok;
   logic differ;
   logic iv_ok;
   logic last_step;

   // compares used by the blocks below
   assign accept    = in_valid && (state_ff == ST_LOAD);
   assign load_ok   = CMP_W'(count_ff) < LEN_CMP;
   assign value_ok  = CMP_W'(in_value) < LEN_CMP;
   assign differ    = CMP_W'(fwd_rdata) != CMP_W'(k_ff);
   assign iv_ok     = CMP_W'(inv_rdata) < LEN_CMP;
   assign last_step = (k_ff + CNT_W'(1)) == count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept && in_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (!last_step) begin
               state_in = ST_READ;
            end else if (rsp_free) begin
               state_in = ST_LOAD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // memory ports, handshake and result
   always_comb begin
      in_ready      = 1'b0;
      fwd_we        = 1'b0;
      fwd_re        = 1'b0;
      fwd_addr      = k_ff[IDX_W-1:0];
      fwd_wdata     = in_value;
      inv_we        = 1'b0;
      inv_re        = 1'b0;
      inv_addr      = k_ff[IDX_W-1:0];
      inv_wdata     = count_ff[IDX_W-1:0];
      result.valid  = 1'b0;
      result.is_odd = parity_ff;
      unique case (state_ff)
         ST_LOAD: begin
            in_ready  = 1'b1;
            fwd_we    = accept && load_ok;
            fwd_addr  = count_ff[IDX_W-1:0];
            inv_we    = accept && load_ok && value_ok;
            inv_addr  = IDX_W'(in_value);
         end
         ST_READ: begin
            fwd_re = 1'b1;
            inv_re = 1'b1;
         end
         ST_WRITE: begin
            // the two half-swaps
            fwd_we        = differ && iv_ok;
            fwd_addr      = inv_rdata;
            fwd_wdata     = fwd_rdata;
            inv_we        = differ && (CMP_W'(fwd_rdata) < LEN_CMP);
            inv_addr      = IDX_W'(fwd_rdata);
            inv_wdata     = inv_rdata;
            result.valid  = last_step && rsp_free;
            result.is_odd = parity_ff ^ differ;
         end
         ST_DONE: begin
            result.valid = rsp_free;
         end
         default: begin
            in_ready = 1'b0;
         end
      endcase
   end

   // entry count, walk index and parity
   always_comb begin
      count_in  = count_ff;
      k_in      = k_ff;
      parity_in = parity_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && load_ok) begin
               count_in = count_ff + CNT_W'(1);
            end
            k_in      = '0;
            parity_in = 1'b0;
         end
         ST_WRITE: begin
            parity_in = parity_ff ^ differ;
            k_in      = k_ff + CNT_W'(1);
            if (last_step && rsp_free) begin
               count_in  = '0;
               parity_in = 1'b0;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               count_in  = '0;
               parity_in = 1'b0;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         count_ff  <= '0;
         k_ff      <= '0;
         parity_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         k_ff      <= k_in;
         parity_ff <= parity_in;
      end
   end

endmodule

// File: hdl/pperm_checker.sv
// port-level checker for the permutation parity core, bound to the top level
`include "permutation_parity_core_defines.svh"

module pperm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [pperm_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic                              req_tlast,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [pperm_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   logic req_word;
   logic unused_data;

   assign req_word    = req_tvalid && req_tready;
   assign unused_data = ^req_tdata;

   // a stalled result word stays put
   `PPERM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result word changed while stalled")

   // the marked word starts the walk, so no word is taken next cycle
   `PPERM_ASSERT_NEXT(a_walk_starts, clock, reset, req_word && req_tlast, !req_tready, "entry stream still ready after the last word")

   // an unmarked word keeps the block loading
   `PPERM_ASSERT_NEXT(a_load_continues, clock, reset, req_word && !req_tlast && !$isunknown(unused_data), req_tready, "entry stream stalled in the middle of a permutation")

   // a new result only comes out of a walk
   `PPERM_ASSERT_SAME(a_rsp_from_walk, clock, reset, $rose(rsp_tvalid), !$past(req_tready), "result appeared without a walk")

endmodule

bind permutation_parity_core pperm_checker u_checker (.*);

// File: tb/sv/tb_permutation_parity_core.sv
// testbench for permutation_parity_core: streamed permutations, parity checked against a predictor
`timescale 1ns / 100ps

module tb_permutation_parity_core;
   import pperm_pkg::*;

   localparam int MAX_LEN = MAX_LEN_DEF;

   typedef int value_q_type[$];

   typedef enum {
      GAPS_NONE,
      GAPS_SEND,
      GAPS_RECV,
      GAPS_BOTH
   } gap_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // [9:0] entry_value, rest zero
   logic                  req_tlast  = 1'b0;  // is_last
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // [0] is_odd, rest zero

   // predictor copy of the block's stores
   bit [VALUE_W-1:0] image_mem     [MAX_LEN];
   bit [VALUE_W-1:0] preimage_mem  [MAX_LEN];
   bit               preimage_known[MAX_LEN];
   int unsigned      entries_held = 0;
   bit               bad_preimage_read = 1'b0;

   // parities still owed by the block, oldest first
   bit odd_flags_pending[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_left = 0;

   int unsigned words_sent = 0;
   int unsigned perms_closed = 0;
   int unsigned parities_checked = 0;
   int unsigned error_count = 0;
   bit          want_odd;

   permutation_parity_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // load one entry; on the end mark walk the stores and give the parity
   function automatic bit parity_fold_entry(input bit [VALUE_W-1:0] value, input bit last,
                                            output bit odd);
      bit [VALUE_W-1:0] img;
      bit [VALUE_W-1:0] pre;
      int unsigned      k;
      int unsigned      n;
      bit               par;
      odd = 1'b0;
      if (entries_held < MAX_LEN) begin
         image_mem[entries_held] = value;
         if (value < MAX_LEN) begin
            preimage_mem[value] = VALUE_W'(entries_held);
            preimage_known[value] = 1'b1;
         end
         entries_held++;
      end
      if (!last)
         return 1'b0;
      n = entries_held;
      par = 1'b0;
      // each displaced index is one transposition
      for (k = 0; k < n; k++) begin
         img = image_mem[k];
         if (img != k) begin
            if (!preimage_known[k])
               bad_preimage_read = 1'b1;
            pre = preimage_mem[k];
            par ^= 1'b1;
            if (pre < MAX_LEN)
               image_mem[pre] = img;
            if (img < MAX_LEN) begin
               preimage_mem[img] = pre;
               preimage_known[img] = 1'b1;
            end
         end
      end
      odd = par;
      entries_held = 0;
      return 1'b1;
   endfunction

   // dry run on the current state: does the walk stay on written entries
   function automatic bit seq_is_safe(value_q_type vals, bit closed);
      bit [VALUE_W-1:0] img_save  [MAX_LEN];
      bit [VALUE_W-1:0] pre_save  [MAX_LEN];
      bit               known_save[MAX_LEN];
      int unsigned      held_save;
      bit               odd_dummy;
      bit               ok;
      img_save = image_mem;
      pre_save = preimage_mem;
      known_save = preimage_known;
      held_save = entries_held;
      bad_preimage_read = 1'b0;
      foreach (vals[i])
         void'(parity_fold_entry(VALUE_W'(vals[i]), closed && (i == vals.size() - 1),
                                 odd_dummy));
      ok = !bad_preimage_read;
      image_mem = img_save;
      preimage_mem = pre_save;
      preimage_known = known_save;
      entries_held = held_save;
      bad_preimage_read = 1'b0;
      return ok;
   endfunction

   function automatic value_q_type make_shuffle(int n);
      value_q_type vals;
      int          i;
      int          j;
      int          tmp;
      for (i = 0; i < n; i++)
         vals.push_back(i);
      for (i = n - 1; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = vals[i];
         vals[i] = vals[j];
         vals[j] = tmp;
      end
      return vals;
   endfunction

   task automatic set_gap_mode(input gap_mode_type mode);
      case (mode)
         GAPS_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         GAPS_SEND: begin send_idle_pct = 63; recv_stall_pct = 0;  end
         GAPS_RECV: begin send_idle_pct = 0;  recv_stall_pct = 63; end
         default:   begin send_idle_pct = 6;  recv_stall_pct = 6;  end
      endcase
   endtask

   // offer one word, wait for the handshake, then predict
   task automatic send_entry(input int value, input bit last);
      bit odd;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(value & ((1 << VALUE_W) - 1));
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      words_sent++;
      if (parity_fold_entry(VALUE_W'(value), last, odd)) begin
         odd_flags_pending.push_back(odd);
         perms_closed++;
      end
   endtask

   task automatic send_perm(input value_q_type vals, input bit closed);
      foreach (vals[i])
         send_entry(vals[i], closed && (i == vals.size() - 1));
   endtask

   // random run: mostly permutations, some repeats and unclosed runs
   task automatic build_random_seq(output value_q_type vals, output bit closed);
      int unsigned pick;
      int unsigned r;
      int          n;
      int          i;
      pick = $urandom_range(99);
      r = $urandom_range(99);
      if (r < 70)
         n = $urandom_range(12, 1);
      else if (r < 95)
         n = $urandom_range(64, 13);
      else
         n = $urandom_range(256, 65);
      vals.delete();
      closed = 1'b1;
      if (pick < 68) begin
         vals = make_shuffle(n);
      end else if (pick < 75) begin
         for (i = 0; i < n; i++)
            vals.push_back(i);
      end else if (pick < 90) begin
         for (i = 0; i < n; i++)
            vals.push_back($urandom_range(1) ? $urandom_range(n - 1) : $urandom_range(1023));
      end else begin
         vals = make_shuffle(n);
         closed = 1'b0;
      end
   endtask

   // short permutations, stale store contents, extreme values, split runs
   task automatic test_small_cases();
      set_gap_mode(GAPS_NONE);
      send_perm('{0}, 1'b1);
      send_perm('{1, 0}, 1'b1);
      send_perm('{1, 2, 0}, 1'b1);
      send_perm('{0, 1}, 1'b1);
      send_perm('{3, 2, 1, 0}, 1'b1);
      send_perm('{1, 1}, 1'b1);
      send_perm('{1023}, 1'b1);
      send_perm('{1}, 1'b0);
      send_perm('{0}, 1'b1);
   endtask

   // whole store depth in reverse, then entries past the depth that are dropped
   task automatic test_overlong();
      value_q_type vals;
      int          i;
      set_gap_mode(GAPS_BOTH);
      for (i = MAX_LEN - 1; i >= 0; i--)
         vals.push_back(i);
      for (i = 0; i < 6; i++)
         vals.push_back($urandom_range(1023));
      send_perm(vals, 1'b1);
   endtask

   task automatic test_random_phases();
      value_q_type  vals;
      bit           closed;
      int unsigned  start;
      gap_mode_type mode;
      for (int p = 0; p < 4; p++) begin
         mode = gap_mode_type'(p);
         set_gap_mode(mode);
         start = words_sent;
         while (words_sent - start < 100) begin
            build_random_seq(vals, closed);
            if (seq_is_safe(vals, closed))
               send_perm(vals, closed);
         end
      end
   endtask

   // receiver holds off while the sender keeps loading short permutations
   task automatic test_result_backpressure();
      set_gap_mode(GAPS_NONE);
      hold_left = 600;
      for (int i = 0; i < 30; i++)
         send_perm(make_shuffle(3), 1'b1);
   endtask

   // receiver: long hold-off when asked, random stalls otherwise
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // compare each accepted result word with the oldest pending parity
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (odd_flags_pending.size() == 0) begin
            $display("%0t: result word with no parity pending, expected none, got is_odd %0d",
                     $time, rsp_tdata[0]);
            error_count++;
         end else begin
            want_odd = odd_flags_pending.pop_front();
            parities_checked++;
            if (rsp_tdata[0] !== want_odd) begin
               $display("%0t: is_odd mismatch, expected %0d, got %0d",
                        $time, want_odd, rsp_tdata[0]);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_small_cases();
      test_overlong();
      test_random_phases();
      test_result_backpressure();
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      // drain, then allow a full walk for any stray result
      while (odd_flags_pending.size() != 0)
         @(posedge clock);
      repeat (2 * MAX_LEN + 16) @(posedge clock);
      $display("covered %0d entry words and %0d closed permutations (full depth, overlong,",
               words_sent, perms_closed);
      $display("repeats, split runs, gaps, long receiver hold), %0d parities compared",
               parities_checked);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
